FILE: rtl/rlf_pkg.sv
// Shared types, constants and reset values of the RGB line FIR filter.
`timescale 1ns / 1ps
package rlf_pkg;
	localparam int MAX_TAPS_DEF = 5;
	localparam int COEFF_FRAC_BITS_DEF = 14;
	localparam int NUM_COEFF = 5;
	localparam int COEFF_W = 16;
	localparam int PIX_W = 8;
	localparam int HALF_W = 2;
	localparam int SEEN_W = 3;
	localparam int TAP_W = 3;
	localparam int IDX_W = 3;
	localparam int PROD_W = 24;
	localparam int ABS_W = 17;
	localparam int SUM_W = 27;
	localparam int DIV_W = 18;
	localparam int STEP_W = 3;

	localparam logic [IDX_W-1:0] REG_COEFF_LAST = 3'd4;
	localparam logic [IDX_W-1:0] REG_TAP_COUNT = 3'd5;
	localparam logic [IDX_W-1:0] REG_NORMALIZE = 3'd6;

	localparam logic [COEFF_W-1:0] COEFF_CENTRE_RST = 16'd16384;
	localparam logic [TAP_W-1:0] TAP_COUNT_RST = 3'd5;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} pix_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] r;
		logic signed [PROD_W-1:0] g;
		logic signed [PROD_W-1:0] b;
		logic [ABS_W-1:0] mag;
	} prod_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_SUM  = 6'b000100,
		S_LOAD = 6'b001000,
		S_DIV  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;
endpackage

FILE: rtl/rlf_if.sv
// Handshake interfaces for pixel input, filtered output and configuration writes.
`timescale 1ns / 1ps
interface rlf_in_if;
	logic valid;
	logic ready;
	logic [rlf_pkg::PIX_W-1:0] red_in;
	logic [rlf_pkg::PIX_W-1:0] green_in;
	logic [rlf_pkg::PIX_W-1:0] blue_in;
	logic line_end_in;
	modport source (output valid, red_in, green_in, blue_in, line_end_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, line_end_in, output ready);
endinterface

interface rlf_out_if;
	logic valid;
	logic ready;
	logic [rlf_pkg::PIX_W-1:0] red_out;
	logic [rlf_pkg::PIX_W-1:0] green_out;
	logic [rlf_pkg::PIX_W-1:0] blue_out;
	logic line_end_out;
	modport source (output valid, red_out, green_out, blue_out, line_end_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, line_end_out, output ready);
endinterface

interface rlf_cfg_if;
	logic valid;
	logic ready;
	logic [rlf_pkg::IDX_W-1:0] index;
	logic [rlf_pkg::COEFF_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/rlf_tap_cell.sv
// One tap cell: holds a window pixel, passes it on, and weighs it by its coefficient.
`timescale 1ns / 1ps
module rlf_tap_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  rlf_pkg::pix_t pix_in,
	output rlf_pkg::pix_t pix,
	input  logic calc,
	input  logic tap_en,
	input  logic signed [rlf_pkg::COEFF_W-1:0] coeff,
	output rlf_pkg::prod_t prod
);
	rlf_pkg::pix_t pix_q;
	rlf_pkg::prod_t prod_q;
	logic signed [rlf_pkg::COEFF_W-1:0] c;
	logic signed [rlf_pkg::COEFF_W:0] c_ext;

	assign c = tap_en ? coeff : '0;
	assign c_ext = {c[rlf_pkg::COEFF_W-1], c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			prod_q <= '0;
		end else begin
			if (shift) begin
				pix_q <= pix_in;
			end
			if (calc) begin
				prod_q.r <= rlf_pkg::PROD_W'(c * $signed({1'b0, pix_q.r}));
				prod_q.g <= rlf_pkg::PROD_W'(c * $signed({1'b0, pix_q.g}));
				prod_q.b <= rlf_pkg::PROD_W'(c * $signed({1'b0, pix_q.b}));
				prod_q.mag <= c_ext[rlf_pkg::COEFF_W] ? rlf_pkg::ABS_W'(-c_ext)
					: rlf_pkg::ABS_W'(c_ext);
			end
		end
	end

	assign pix = pix_q;
	assign prod = prod_q;
endmodule

FILE: rtl/rlf_chan_div.sv
// Channel scaler: a shift by the fraction bits, or restoring division one bit a cycle, clamped.
`timescale 1ns / 1ps
module rlf_chan_div #(
	parameter int FRAC_BITS = rlf_pkg::COEFF_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic load,
	input  logic step,
	input  logic norm,
	input  logic [rlf_pkg::STEP_W-1:0] bit_idx,
	input  logic signed [rlf_pkg::SUM_W-1:0] sum,
	input  logic [rlf_pkg::DIV_W-1:0] divisor,
	output logic [rlf_pkg::PIX_W-1:0] quo
);
	logic [rlf_pkg::SUM_W-1:0] sum_u;
	logic [rlf_pkg::SUM_W-1:0] rem_q;
	logic [rlf_pkg::PIX_W-1:0] quo_q;
	logic zero_q;
	logic sat_q;
	logic norm_q;
	logic [rlf_pkg::SUM_W-1:0] div_ext;
	logic [rlf_pkg::SUM_W-1:0] div_sh;

	assign sum_u = $unsigned(sum);
	assign div_ext = rlf_pkg::SUM_W'(divisor);
	assign div_sh = div_ext << bit_idx;

	always_ff @(posedge clk) begin
		if (load) begin
			norm_q <= norm;
			zero_q <= (sum <= 0) || (norm && (divisor == '0));
			if (norm) begin
				sat_q <= sum_u >= (div_ext << rlf_pkg::PIX_W);
			end else begin
				sat_q <= sum_u >= (rlf_pkg::SUM_W'(1) << (FRAC_BITS + rlf_pkg::PIX_W));
			end
			rem_q <= sum_u;
			quo_q <= norm ? '0 : sum_u[FRAC_BITS +: rlf_pkg::PIX_W];
		end else if (step && norm_q) begin
			if (rem_q >= div_sh) begin
				rem_q <= rem_q - div_sh;
				quo_q[bit_idx] <= 1'b1;
			end
		end
	end

	assign quo = zero_q ? '0 : (sat_q ? '1 : quo_q);
endmodule

FILE: rtl/rgb_line_fir_filter_core.sv
// Top level of the RGB line FIR filter: config registers, tap cell chain, sequencer, dividers.
// Each result of a pixel passes the multiply, sum, load and divide states before it is valid.
// Each further result of a line end is computed only after the previous one is taken.
// The input is held until a pending result is taken; the 8-step dividers are shared by all taps.
// A line end with up to three results holds the input until its last result is taken.
// Reset clears the configuration to its defaults, the pixel count and the sequencer.
`timescale 1ns / 1ps
module rgb_line_fir_filter_core #(
	parameter int MAX_TAPS = rlf_pkg::MAX_TAPS_DEF,
	parameter int COEFF_FRAC_BITS = rlf_pkg::COEFF_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rlf_cfg_if.sink cfg,
	rlf_in_if.sink pix_in,
	rlf_out_if.source pix_out
);
	localparam int HALF_MAX = (MAX_TAPS - 1) / 2;

	logic signed [rlf_pkg::COEFF_W-1:0] coeff_q [rlf_pkg::NUM_COEFF];
	logic [rlf_pkg::TAP_W-1:0] tap_count_q;
	logic norm_q;

	rlf_pkg::state_t state_q;
	logic [rlf_pkg::SEEN_W-1:0] seen_q;
	logic [rlf_pkg::SEEN_W-1:0] p_q;
	logic [rlf_pkg::HALF_W-1:0] half_q;
	logic [rlf_pkg::HALF_W-1:0] d_q;
	logic end_q;
	logic [rlf_pkg::STEP_W-1:0] cnt_q;

	logic in_acc;
	logic out_acc;
	logic [rlf_pkg::TAP_W-1:0] half_raw;
	logic [rlf_pkg::HALF_W-1:0] half_now;
	logic emit_now;
	logic last_res;

	rlf_pkg::pix_t pix_new;
	rlf_pkg::pix_t cell_pix [MAX_TAPS];
	rlf_pkg::prod_t cell_prod [MAX_TAPS];

	logic signed [rlf_pkg::SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [rlf_pkg::DIV_W-1:0] mag_q;
	logic signed [rlf_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
	logic [rlf_pkg::DIV_W-1:0] mag_sum;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rlf_pkg::NUM_COEFF; i++) begin
				coeff_q[i] <= '0;
			end
			coeff_q[2] <= rlf_pkg::COEFF_CENTRE_RST;
			tap_count_q <= rlf_pkg::TAP_COUNT_RST;
			norm_q <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.index <= rlf_pkg::REG_COEFF_LAST) begin
				coeff_q[cfg.index] <= cfg.data;
			end else if (cfg.index == rlf_pkg::REG_TAP_COUNT) begin
				tap_count_q <= cfg.data[rlf_pkg::TAP_W-1:0];
			end else if (cfg.index == rlf_pkg::REG_NORMALIZE) begin
				norm_q <= cfg.data[0];
			end
		end
	end

	assign half_raw = tap_count_q >> 1;
	assign half_now = (half_raw > rlf_pkg::TAP_W'(HALF_MAX)) ? rlf_pkg::HALF_W'(HALF_MAX)
		: half_raw[rlf_pkg::HALF_W-1:0];

	assign pix_in.ready = (state_q == rlf_pkg::S_IDLE);
	assign in_acc = pix_in.valid && pix_in.ready;
	assign out_acc = pix_out.valid && pix_out.ready;
	assign emit_now = pix_in.line_end_in
		|| (seen_q >= rlf_pkg::SEEN_W'(half_now));
	assign last_res = end_q ? (d_q == '0) : 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlf_pkg::S_IDLE;
			seen_q <= '0;
			p_q <= '0;
			half_q <= '0;
			d_q <= '0;
			end_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				rlf_pkg::S_IDLE: begin
					if (in_acc) begin
						p_q <= seen_q;
						half_q <= half_now;
						end_q <= pix_in.line_end_in;
						if (pix_in.line_end_in
							&& seen_q < rlf_pkg::SEEN_W'(half_now)) begin
							d_q <= seen_q[rlf_pkg::HALF_W-1:0];
						end else begin
							d_q <= half_now;
						end
						if (pix_in.line_end_in) begin
							seen_q <= '0;
						end else if (seen_q != '1) begin
							seen_q <= seen_q + 1'b1;
						end
						if (emit_now) begin
							state_q <= rlf_pkg::S_MUL;
						end
					end
				end
				rlf_pkg::S_MUL: state_q <= rlf_pkg::S_SUM;
				rlf_pkg::S_SUM: state_q <= rlf_pkg::S_LOAD;
				rlf_pkg::S_LOAD: begin
					cnt_q <= '1;
					state_q <= rlf_pkg::S_DIV;
				end
				rlf_pkg::S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= rlf_pkg::S_OUT;
					end
				end
				rlf_pkg::S_OUT: begin
					if (out_acc) begin
						if (last_res) begin
							state_q <= rlf_pkg::S_IDLE;
						end else begin
							d_q <= d_q - 1'b1;
							state_q <= rlf_pkg::S_MUL;
						end
					end
				end
				default: state_q <= rlf_pkg::S_IDLE;
			endcase
		end
	end

	assign pix_new.r = pix_in.red_in;
	assign pix_new.g = pix_in.green_in;
	assign pix_new.b = pix_in.blue_in;

	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
		logic signed [3:0] k;
		logic tap_en;
		logic signed [rlf_pkg::COEFF_W-1:0] c_sel;

		assign k = $signed({2'b00, d_q}) + $signed({2'b00, half_q}) - 4'(j);
		assign tap_en = (k >= 0) && (k <= $signed({1'b0, half_q, 1'b0}))
			&& (rlf_pkg::SEEN_W'(j) <= p_q);
		assign c_sel = tap_en ? coeff_q[k[2:0]] : '0;

		rlf_tap_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.shift(in_acc),
			.pix_in((j == 0) ? pix_new : cell_pix[(j == 0) ? 0 : j - 1]),
			.pix(cell_pix[j]),
			.calc(state_q == rlf_pkg::S_MUL),
			.tap_en(tap_en),
			.coeff(c_sel),
			.prod(cell_prod[j])
		);
	end

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		mag_sum = '0;
		for (int j = 0; j < MAX_TAPS; j++) begin
			sum_r = sum_r + rlf_pkg::SUM_W'(cell_prod[j].r);
			sum_g = sum_g + rlf_pkg::SUM_W'(cell_prod[j].g);
			sum_b = sum_b + rlf_pkg::SUM_W'(cell_prod[j].b);
			mag_sum = mag_sum + rlf_pkg::DIV_W'(cell_prod[j].mag);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rlf_pkg::S_SUM) begin
			sum_r_q <= sum_r;
			sum_g_q <= sum_g;
			sum_b_q <= sum_b;
			mag_q <= mag_sum;
		end
	end

	rlf_chan_div #(.FRAC_BITS(COEFF_FRAC_BITS)) u_div_r (
		.clk(clk), .load(state_q == rlf_pkg::S_LOAD), .step(state_q == rlf_pkg::S_DIV),
		.norm(norm_q), .bit_idx(cnt_q), .sum(sum_r_q), .divisor(mag_q),
		.quo(pix_out.red_out)
	);
	rlf_chan_div #(.FRAC_BITS(COEFF_FRAC_BITS)) u_div_g (
		.clk(clk), .load(state_q == rlf_pkg::S_LOAD), .step(state_q == rlf_pkg::S_DIV),
		.norm(norm_q), .bit_idx(cnt_q), .sum(sum_g_q), .divisor(mag_q),
		.quo(pix_out.green_out)
	);
	rlf_chan_div #(.FRAC_BITS(COEFF_FRAC_BITS)) u_div_b (
		.clk(clk), .load(state_q == rlf_pkg::S_LOAD), .step(state_q == rlf_pkg::S_DIV),
		.norm(norm_q), .bit_idx(cnt_q), .sum(sum_b_q), .divisor(mag_q),
		.quo(pix_out.blue_out)
	);

	assign pix_out.valid = (state_q == rlf_pkg::S_OUT);
	assign pix_out.line_end_out = end_q && (d_q == '0);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_in.ready && pix_out.valid))
		else $error("input taken while a result is pending");

	a_skip_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !emit_now |=> state_q == rlf_pkg::S_IDLE)
		else $error("pixel without result left the idle state");

	a_line_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && pix_in.line_end_in |=> seen_q == '0)
		else $error("pixel count not cleared at line end");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && pix_out.line_end_out |=> pix_in.ready)
		else $error("input not freed after the last beat of a line");
endmodule

FILE: verif/rgb_line_fir_filter_core_tb.sv
// Self-checking testbench of the RGB line FIR filter: directed table, random lines, scoreboard.
`timescale 1ns / 1ps
module rgb_line_fir_filter_core_tb;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [rlf_pkg::IDX_W-1:0] REG_COEFF_FIRST = 3'd0;
	localparam logic [rlf_pkg::IDX_W-1:0] REG_COEFF_1 = 3'd1;
	localparam logic [rlf_pkg::IDX_W-1:0] REG_COEFF_2 = 3'd2;
	localparam logic [rlf_pkg::IDX_W-1:0] REG_COEFF_3 = 3'd3;
	localparam logic [rlf_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic last;
	} fpix_t;

	typedef struct {
		rlf_pkg::pix_t px;
		logic last;
		logic chk;
		fpix_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rlf_cfg_if cfg ();
	rlf_in_if pix_in ();
	rlf_out_if pix_out ();

	rgb_line_fir_filter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pix_in(pix_in),
		.pix_out(pix_out)
	);

	always #5 clk = ~clk;

	logic signed [15:0] m_coeff [5];
	logic [2:0] m_taps;
	logic m_norm;
	rlf_pkg::pix_t m_hist [4];
	int m_seen;

	fpix_t filtered_q [$];
	int errors = 0;
	int idle_cycles = 0;
	bit sink_wild = 1'b1;

	function automatic logic [7:0] scale_channel(longint acc, longint mag);
		longint q;
		if (acc <= 0)
			return 8'd0;
		if (m_norm) begin
			if (mag == 0)
				return 8'd0;
			q = acc / mag;
		end else begin
			q = acc >>> rlf_pkg::COEFF_FRAC_BITS_DEF;
		end
		return q > 255 ? 8'd255 : q[7:0];
	endfunction

	function automatic fpix_t filter_at(rlf_pkg::pix_t win [5], int p, int half, int d,
			logic last);
		longint sr, sg, sb, mag, c;
		int j;
		fpix_t o;
		sr = 0; sg = 0; sb = 0; mag = 0;
		for (int k = 0; k <= 2 * half; k++) begin
			j = d + half - k;
			if (j < 0 || j > p || j > 4)
				continue;
			c = m_coeff[k];
			sr += c * win[j].r;
			sg += c * win[j].g;
			sb += c * win[j].b;
			mag += c < 0 ? -c : c;
		end
		o.r = scale_channel(sr, mag);
		o.g = scale_channel(sg, mag);
		o.b = scale_channel(sb, mag);
		o.last = last;
		return o;
	endfunction

	// Returns the number of filtered pixels that this beat produces.
	function automatic int predict_pixel(rlf_pkg::pix_t px, logic last);
		rlf_pkg::pix_t win [5];
		int half, n;
		half = m_taps >> 1;
		if (half > 2)
			half = 2;
		n = 0;
		win[0] = px;
		for (int j = 1; j < 5; j++)
			win[j] = m_hist[j-1];
		if (!last) begin
			if (m_seen >= half) begin
				filtered_q.push_back(filter_at(win, m_seen, half, half, 1'b0));
				n = 1;
			end
		end else begin
			for (int d = half; d >= 0; d--)
				if (d <= m_seen) begin
					filtered_q.push_back(filter_at(win, m_seen, half, d, d == 0));
					n++;
				end
		end
		for (int j = 0; j < 4; j++)
			m_hist[j] = win[j];
		if (last)
			m_seen = 0;
		else if (m_seen < 7)
			m_seen++;
		return n;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		return r < 93 ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	task automatic write_reg(logic [rlf_pkg::IDX_W-1:0] idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		if (idx <= rlf_pkg::REG_COEFF_LAST)
			m_coeff[idx] = val;
		else if (idx == rlf_pkg::REG_TAP_COUNT)
			m_taps = val[2:0];
		else if (idx == rlf_pkg::REG_NORMALIZE)
			m_norm = val[0];
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (filtered_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Sends one beat; a row with chk set also checks the typed-in result.
	task automatic send_pixel(rlf_pkg::pix_t px, logic last, logic chk, fpix_t want,
			bit gaps);
		int n;
		int g;
		pix_in.valid <= 1'b1;
		pix_in.red_in <= px.r;
		pix_in.green_in <= px.g;
		pix_in.blue_in <= px.b;
		pix_in.line_end_in <= last;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		n = predict_pixel(px, last);
		if (chk && (n == 0 || filtered_q[$] !== want)) begin
			$display("%0t: table row expected %h, predicted %h", $time, want,
				n ? filtered_q[$] : fpix_t'('0));
			errors++;
		end
		if (gaps && $urandom_range(0, 2) == 0) begin
			g = gap_len();
			if (g > 0) begin
				pix_in.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	task automatic set_kernel(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2,
			logic [15:0] c3, logic [15:0] c4, logic [2:0] taps, logic norm);
		pix_in.valid <= 1'b0;
		wait_drained();
		write_reg(REG_COEFF_FIRST, c0);
		write_reg(REG_COEFF_1, c1);
		write_reg(REG_COEFF_2, c2);
		write_reg(REG_COEFF_3, c3);
		write_reg(rlf_pkg::REG_COEFF_LAST, c4);
		write_reg(rlf_pkg::REG_TAP_COUNT, {13'd0, taps});
		write_reg(rlf_pkg::REG_NORMALIZE, {15'd0, norm});
	endtask

	task automatic random_line(int len, bit gaps);
		rlf_pkg::pix_t px;
		for (int i = 0; i < len; i++) begin
			px = rlf_pkg::pix_t'($urandom());
			if ($urandom_range(0, 7) == 0)
				px = $urandom_range(0, 1) ? rlf_pkg::pix_t'('1) : rlf_pkg::pix_t'('0);
			send_pixel(px, i == len - 1, 1'b0, '0, gaps);
		end
	endtask

	always @(posedge clk) begin
		if (pix_out.valid && pix_out.ready) begin
			if (filtered_q.size() == 0) begin
				$display("%0t: unexpected beat, actual %h", $time,
					{pix_out.red_out, pix_out.green_out, pix_out.blue_out,
					pix_out.line_end_out});
				errors++;
			end else begin
				fpix_t w, a;
				w = filtered_q.pop_front();
				a = {pix_out.red_out, pix_out.green_out, pix_out.blue_out,
					pix_out.line_end_out};
				if (a.r !== w.r) begin
					$display("%0t: red expected %0d actual %0d", $time, w.r, a.r);
					errors++;
				end
				if (a.g !== w.g) begin
					$display("%0t: green expected %0d actual %0d", $time, w.g, a.g);
					errors++;
				end
				if (a.b !== w.b) begin
					$display("%0t: blue expected %0d actual %0d", $time, w.b, a.b);
					errors++;
				end
				if (a.last !== w.last) begin
					$display("%0t: line end expected %0d actual %0d", $time, w.last,
						a.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			pix_out.ready <= 1'b0;
		else if (!sink_wild)
			pix_out.ready <= 1'b1;
		else
			pix_out.ready <= $urandom_range(0, 99) < ($urandom_range(0, 9) == 0 ? 5 : 70);
	end

	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	stim_row_t table_rows [20];

	initial begin
		int sent;
		pix_in.valid = 1'b0;
		pix_in.red_in = '0;
		pix_in.green_in = '0;
		pix_in.blue_in = '0;
		pix_in.line_end_in = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		m_coeff = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
		m_taps = rlf_pkg::TAP_COUNT_RST;
		m_norm = 1'b0;
		m_hist = '{default: '0};
		m_seen = 0;

		// Identity kernel after reset: a checked row expects its window centre pixel, at a line end the beat itself.
		table_rows[0] = '{rlf_pkg::pix_t'('1), 1'b0, 1'b0, '0};
		table_rows[1] = '{rlf_pkg::pix_t'('0), 1'b0, 1'b0, '0};
		table_rows[2] = '{rlf_pkg::pix_t'(24'h80_01_FE), 1'b0, 1'b1,
			fpix_t'({24'hFF_FF_FF, 1'b0})};
		table_rows[3] = '{rlf_pkg::pix_t'(24'h12_34_56), 1'b1, 1'b1,
			fpix_t'({24'h12_34_56, 1'b1})};
		table_rows[4] = '{rlf_pkg::pix_t'(24'hAA_55_0F), 1'b1, 1'b1,
			fpix_t'({24'hAA_55_0F, 1'b1})};
		table_rows[5] = '{rlf_pkg::pix_t'(24'h01_02_03), 1'b0, 1'b0, '0};
		table_rows[6] = '{rlf_pkg::pix_t'(24'hFF_00_FF), 1'b1, 1'b1,
			fpix_t'({24'hFF_00_FF, 1'b1})};
		for (int i = 7; i < 20; i++)
			table_rows[i] = '{rlf_pkg::pix_t'($urandom()), i % 5 == 4, 1'b0, '0};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			send_pixel(table_rows[i].px, table_rows[i].last, table_rows[i].chk,
				table_rows[i].want, 1'b0);

		// Extremes: negative full scale, tap count zero, even, above maximum, out of range index, all-zero kernel.
		set_kernel(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 3'd5, 1'b0);
		random_line(6, 1'b0);
		set_kernel(16'h4000, 16'h1234, 16'h4321, 16'hFFFF, 16'h0001, 3'd0, 1'b1);
		random_line(3, 1'b0);
		set_kernel(16'h2000, 16'hE000, 16'h4000, 16'h2000, 16'h1000, 3'd2, 1'b1);
		random_line(1, 1'b0);
		random_line(4, 1'b0);
		set_kernel(16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 3'd7, 1'b0);
		write_reg(REG_UNUSED, 16'hFFFF);
		random_line(2, 1'b0);
		random_line(5, 1'b0);
		set_kernel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd4, 1'b1);
		random_line(5, 1'b0);

		sent = 0;
		while (sent < 425) begin
			int len;
			if ($urandom_range(0, 3) == 0) begin
				set_kernel(16'($urandom()), 16'($urandom()), 16'($urandom()),
					16'($urandom()), 16'($urandom()), 3'($urandom_range(0, 7)),
					1'($urandom_range(0, 1)));
				if ($urandom_range(0, 3) == 0)
					write_reg(REG_UNUSED, 16'($urandom()));
			end
			sink_wild = $urandom_range(0, 4) != 0;
			len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 14);
			random_line(len, $urandom_range(0, 3) != 0);
			sent += len;
		end

		pix_in.valid <= 1'b0;
		sink_wild = 1'b1;
		wait_drained();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
